FILE: design/rgb_split_screen_blend_top_assert.svh
// ----------------------------------------------------------------------------
// RGB split screen blend - assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_SPLIT_SCREEN_BLEND_TOP_ASSERT_SVH
`define RGB_SPLIT_SCREEN_BLEND_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define RSSB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rssb assertion failed");
// next-cycle implication
`define RSSB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rssb assertion failed");
`else
`define RSSB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define RSSB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/rssb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - package
// Widths, store depths, the blend command word and the screen function.
// ----------------------------------------------------------------------------
package rssb_pkg;

  localparam int CH_W        = 8;
  localparam int SHIFT_W     = 4;
  localparam int CNT_W       = 16;
  localparam int MAX_SHIFT   = 15;
  localparam int WIN_DEPTH   = MAX_SHIFT + 1;
  localparam int WIN_AW      = $clog2(WIN_DEPTH);
  localparam int HIST_DEPTH  = MAX_SHIFT;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(3);
  localparam logic [CH_W-1:0]    CH_WHITE    = '1;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // one pixel to blend, as handed from the front end to the blend stage
  typedef struct packed {
    pixel_t             px;
    logic [CH_W-1:0]    green_nb;
    logic [CH_W-1:0]    blue_nb;
    logic               use_hist;
    logic [HIST_AW-1:0] rd_idx;
    logic [HIST_AW-1:0] wr_idx;
    logic               row_end;
    logic               run_last;
  } blend_cmd_t;

  // screen: 255 - ceil((255-a)(255-b)/255); x/255 as (x + (x>>8) + 1) >> 8
  function automatic logic [CH_W-1:0] screen8(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0]   na;
    logic [CH_W-1:0]   nb;
    logic [2*CH_W-1:0] p;
    logic [2*CH_W:0]   x;
    logic [2*CH_W:0]   q;
    na = ~a;
    nb = ~b;
    p = {{CH_W{1'b0}}, na} * {{CH_W{1'b0}}, nb};
    x = {1'b0, p} + (2*CH_W+1)'(254);
    q = (x + (x >> CH_W) + (2*CH_W+1)'(1)) >> CH_W;
    return ~q[CH_W-1:0];
  endfunction

endpackage

FILE: design/rssb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - pixel input channel
// Valid/ready channel carrying one RGBA pixel and its row end flag.
// ----------------------------------------------------------------------------
interface rssb_in_if import rssb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;
  logic            row_end_in;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, output row_end_in, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, input row_end_in, output ready);
endinterface

FILE: design/rssb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - pixel output channel
// Valid/ready channel carrying one blended pixel with its markers.
// ----------------------------------------------------------------------------
interface rssb_out_if import rssb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic            row_end_out;
  logic            run_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output row_end_out, output run_last,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, input row_end_out, input run_last,
                output ready);
endinterface

FILE: design/rssb_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - configuration channel
// Valid/ready write channel for the shift register.
// ----------------------------------------------------------------------------
interface rssb_cfg_if import rssb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SHIFT_W-1:0] shift;

  modport source (output valid, output shift, input ready);
  modport sink (input valid, input shift, output ready);
endinterface

FILE: design/rssb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - front end
// Takes pixels, keeps the pixel window and column counters, and issues one
// blend command per emitted pixel, including the row end flush.
// ----------------------------------------------------------------------------
`include "rgb_split_screen_blend_top_assert.svh"

module rssb_front import rssb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rssb_in_if.sink    pix_in,
  rssb_cfg_if.sink   cfg,
  input  logic       q_full,
  output logic       cmd_push,
  output blend_cmd_t cmd
);

  localparam int HSUM_W = HIST_AW + 1;

  logic [SHIFT_W-1:0] cfg_shift;
  logic [SHIFT_W-1:0] row_shift;
  logic [SHIFT_W-1:0] shift_sat;
  logic [SHIFT_W-1:0] s_eff;
  logic [SHIFT_W-1:0] s_mod;
  logic [SHIFT_W-1:0] flush_left;
  logic               row_active;
  logic               flushing;
  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   emit;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   remaining;
  logic [HIST_AW-1:0] emit_m15;
  logic [HIST_AW-1:0] emit_m15_next;
  logic [HSUM_W-1:0]  rd_sum;
  logic [HIST_AW-1:0] rd_idx;
  logic               accept;
  logic               emit_norm;
  logic               flush_push;
  logic               advance;
  pixel_t             window [WIN_DEPTH];
  pixel_t             pix_new;

  // handshakes: input stalls during a flush or with the queue full
  assign pix_in.ready = !flushing && !q_full;
  assign cfg.ready    = 1'b1;
  assign accept       = pix_in.valid && pix_in.ready;

  // shift for this row: latched at the first pixel, zero reads as one
  assign shift_sat = (cfg_shift == '0) ? SHIFT_W'(1) : cfg_shift;
  assign s_eff     = row_active ? row_shift : shift_sat;

  // emission decision
  assign held       = col - emit;
  assign emit_norm  = accept && (held >= CNT_W'(s_eff));
  assign flush_push = flushing && !q_full;
  assign advance    = emit_norm || flush_push;
  assign remaining  = col + CNT_W'(1) - emit - CNT_W'(emit_norm);

  // red history addressing, column modulo the history depth
  assign s_mod  = (s_eff == SHIFT_W'(HIST_DEPTH)) ? '0 : s_eff;
  assign rd_sum = HSUM_W'(emit_m15) + HSUM_W'(HIST_DEPTH) - HSUM_W'(s_mod);
  assign rd_idx = (rd_sum >= HSUM_W'(HIST_DEPTH)) ?
                  rd_sum[HIST_AW-1:0] - HIST_AW'(HIST_DEPTH) : rd_sum[HIST_AW-1:0];
  assign emit_m15_next = (emit == '1 || emit_m15 == HIST_AW'(HIST_DEPTH - 1)) ?
                         '0 : emit_m15 + HIST_AW'(1);

  // command word
  assign cmd_push         = advance;
  assign cmd.px           = window[emit[WIN_AW-1:0]];
  assign cmd.green_nb     = flushing ? CH_WHITE : pix_in.in_green;
  assign cmd.blue_nb      = flushing ? CH_WHITE : pix_in.in_blue;
  assign cmd.use_hist     = emit > CNT_W'(s_eff);
  assign cmd.rd_idx       = rd_idx;
  assign cmd.wr_idx       = emit_m15;
  assign cmd.row_end      = flushing && (flush_left == SHIFT_W'(1));
  assign cmd.run_last     = flushing ? (flush_left == SHIFT_W'(1)) : !pix_in.row_end_in;

  assign pix_new.red   = pix_in.in_red;
  assign pix_new.green = pix_in.in_green;
  assign pix_new.blue  = pix_in.in_blue;
  assign pix_new.alpha = pix_in.in_alpha;

  // pixel window, written by column
  always_ff @(posedge clk) begin
    if (accept) begin
      window[col[WIN_AW-1:0]] <= pix_new;
    end
  end

  // counters, row state and flush sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_shift  <= SHIFT_RESET;
      row_shift  <= '0;
      row_active <= 1'b0;
      flushing   <= 1'b0;
      flush_left <= '0;
      col        <= '0;
      emit       <= '0;
      emit_m15   <= '0;
    end else begin
      if (cfg.valid) begin
        cfg_shift <= cfg.shift;
      end
      if (accept) begin
        if (!row_active) begin
          row_shift <= shift_sat;
        end
        row_active <= 1'b1;
        if (pix_in.row_end_in) begin
          col        <= '0;
          flushing   <= 1'b1;
          flush_left <= remaining[SHIFT_W-1:0];
        end else begin
          col <= col + CNT_W'(1);
        end
      end
      // last flush word rewinds the emit counter, any other word steps it
      if (flush_push && flush_left == SHIFT_W'(1)) begin
        flushing   <= 1'b0;
        row_active <= 1'b0;
        emit       <= '0;
        emit_m15   <= '0;
      end else if (advance) begin
        emit     <= emit + CNT_W'(1);
        emit_m15 <= emit_m15_next;
      end
      if (flush_push) begin
        flush_left <= flush_left - SHIFT_W'(1);
      end
    end
  end

  // never more than one shift's worth of pixels held mid row
  `RSSB_ASSERT_IMPLIES(a_held_bound, clk, rst, row_active && !flushing, held <= CNT_W'(row_shift))
  // the last flush word ends the row and rewinds the emit counter
  `RSSB_ASSERT_NEXT(a_flush_done, clk, rst, flush_push && flush_left == SHIFT_W'(1), !flushing && emit == '0)
  // no input taken while a flush is running
  `RSSB_ASSERT_IMPLIES(a_no_take_in_flush, clk, rst, flushing, !accept)

endmodule

FILE: design/rssb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - command queue
// Short FIFO of blend commands between the front end and the blend stage.
// ----------------------------------------------------------------------------
`include "rgb_split_screen_blend_top_assert.svh"

module rssb_queue import rssb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  blend_cmd_t push_data,
  output logic       full,
  input  logic       pop,
  output blend_cmd_t pop_data,
  output logic       not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  blend_cmd_t        store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_pop;

  assign full      = (count == CNT_QW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = store[rd_ptr];
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  // front end must hold off while the queue is full
  `RSSB_ASSERT_IMPLIES(a_no_overrun, clk, rst, push, !full)

endmodule

FILE: design/rssb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - blend stage
// Screen-blends each command against its neighbours, keeps the blended red
// history and holds the result in the output register.
// ----------------------------------------------------------------------------
module rssb_back import rssb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  blend_cmd_t cmd,
  output logic       cmd_pop,
  rssb_out_if.source pix_out
);

  logic [CH_W-1:0] red_hist [HIST_DEPTH];
  logic [CH_W-1:0] red_nb;
  logic [CH_W-1:0] red_new;
  logic [CH_W-1:0] green_new;
  logic [CH_W-1:0] blue_new;
  logic            out_valid;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic            row_end_out;
  logic            run_last;

  // take a word when the output register is free or being emptied
  assign cmd_pop = cmd_valid && (!out_valid || pix_out.ready);

  // blends: red against the earlier blended red, or white at the row start
  assign red_nb    = cmd.use_hist ? red_hist[cmd.rd_idx] : CH_WHITE;
  assign red_new   = screen8(cmd.px.red, red_nb);
  assign green_new = screen8(cmd.px.green, cmd.green_nb);
  assign blue_new  = screen8(cmd.px.blue, cmd.blue_nb);

  // red history and output payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      red_hist[cmd.wr_idx] <= red_new;
      out_red              <= red_new;
      out_green            <= green_new;
      out_blue             <= blue_new;
      out_alpha            <= cmd.px.alpha;
      row_end_out          <= cmd.row_end;
      run_last             <= cmd.run_last;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.out_red     = out_red;
  assign pix_out.out_green   = out_green;
  assign pix_out.out_blue    = out_blue;
  assign pix_out.out_alpha   = out_alpha;
  assign pix_out.row_end_out = row_end_out;
  assign pix_out.run_last    = run_last;

endmodule

FILE: design/rgb_split_screen_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - top level
// Channel-shift screen blend on a raster RGBA stream: front end, command
// queue and blend stage.
//
//   channel   dir   payload                                         words
//   pix_in    in    in_red/green/blue/alpha, row_end_in             pixels
//   pix_out   out   out_red/green/blue/alpha, row_end_out, run_last pixels
//   cfg       in    shift                                           writes
//
// One pixel per cycle inside a row while neither side stalls; the word for each
// pixel passes through the queue and then the output register.
// At a row end the input stalls while the front end flushes the window,
// one flush word per pixel still held (1 to shift pixels).
// Synchronous reset clears the counters, row state, queue and output valid and
// reloads the shift; the pixel window and red history need no clearing pass.
// Either side may stall on its own; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module rgb_split_screen_blend_top import rssb_pkg::*; #(
  parameter int QUEUE_DEPTH = rssb_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  rssb_in_if.sink    pix_in,
  rssb_out_if.source pix_out,
  rssb_cfg_if.sink   cfg
);

  blend_cmd_t push_cmd;
  blend_cmd_t pop_cmd;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;

  // front end
  rssb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .q_full   (q_full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  // command queue
  rssb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .not_empty (q_not_empty)
  );

  // blend stage
  rssb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .pix_out   (pix_out)
  );

endmodule

FILE: tb/tb_rgb_split_screen_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB split screen blend - testbench
// Feeds raster rows of RGBA pixels and shift writes into the block, with
// random gaps and output stalls. A local screen-blend predictor builds the
// blended pixels each accepted word should produce, and every output word is
// checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module tb_rgb_split_screen_blend_top;
  import rssb_pkg::*;

  localparam int DRAIN_CYCLES = 40;       // quiet time before a shift write
  localparam int END_CYCLES   = 40;       // settling time at the end
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int RAND_PIXELS  = 450;

  // one blended pixel as it should leave the block
  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            row_end;
    logic            run_last;
  } blended_t;

  // one pending stimulus entry: a pixel word or a shift write
  typedef struct {
    bit                 is_cfg;
    logic [SHIFT_W-1:0] shift;
    pixel_t             px;
    logic               row_end;
  } stim_t;

  logic clk;
  logic rst;

  rssb_in_if  pix_in ();
  rssb_out_if pix_out ();
  rssb_cfg_if cfg ();

  rgb_split_screen_blend_top dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  stim_t    stim_q[$];
  blended_t blended_q[$];
  stim_t    pend;

  // predictor state; rows stay far below the 16-bit counter wrap
  pixel_t          window [WIN_DEPTH];
  logic [CH_W-1:0] red_hist [HIST_DEPTH];
  logic [SHIFT_W-1:0] shift_reg = SHIFT_RESET;
  int              row_shift = 0;
  bit              row_open = 1'b0;
  int              col_cnt = 0;
  int              emit_cnt = 0;

  // handshake bookkeeping between monitor and driver
  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit out_taken = 1'b0;
  bit in_busy = 1'b0;
  bit cfg_busy = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  pixel_t   seen_px;
  blended_t got;
  blended_t want;

  // screen: 255 - ceil((255-a)(255-b)/255)
  function automatic logic [CH_W-1:0] screen_blend(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
    int p;
    p = (255 - int'(a)) * (255 - int'(b));
    return CH_W'(255 - (p + 254) / 255);
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SHIFT_W'(1);
      2: return '1;
      default: return SHIFT_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic add_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b, input logic [CH_W-1:0] a,
                           input logic last);
    stim_t e;
    e.is_cfg     = 1'b0;
    e.shift      = '0;
    e.px.red     = r;
    e.px.green   = g;
    e.px.blue    = b;
    e.px.alpha   = a;
    e.row_end    = last;
    stim_q.push_back(e);
  endtask

  task automatic add_rand_pixel(input logic last);
    add_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), last);
  endtask

  task automatic add_shift(input logic [SHIFT_W-1:0] value);
    stim_t e;
    e.is_cfg  = 1'b1;
    e.shift   = value;
    e.px      = '0;
    e.row_end = 1'b0;
    stim_q.push_back(e);
  endtask

  // emit the next held pixel with the given green/blue neighbours
  task automatic emit_blended(input logic [CH_W-1:0] g_nb, input logic [CH_W-1:0] b_nb,
                              input logic last);
    int              c;
    pixel_t          px;
    logic [CH_W-1:0] red_nb;
    blended_t        res;
    c      = emit_cnt;
    px     = window[c % WIN_DEPTH];
    red_nb = CH_WHITE;
    if (c > row_shift) begin
      red_nb = red_hist[(c - row_shift) % HIST_DEPTH];
    end
    res.red          = screen_blend(px.red, red_nb);
    red_hist[c % HIST_DEPTH] = res.red;
    res.green        = screen_blend(px.green, g_nb);
    res.blue         = screen_blend(px.blue, b_nb);
    res.alpha        = px.alpha;
    res.row_end      = last;
    res.run_last     = 1'b0;
    blended_q.push_back(res);
    emit_cnt++;
  endtask

  // expected words for one accepted pixel
  task automatic blend_pixel(input pixel_t px, input logic last);
    int held;
    int first;
    int s;
    if (!row_open) begin
      s = (shift_reg == '0) ? 1 : int'(shift_reg);
      if (s > MAX_SHIFT) s = MAX_SHIFT;
      row_shift = s;
      row_open  = 1'b1;
    end
    first = blended_q.size();
    window[col_cnt % WIN_DEPTH] = px;
    held = col_cnt - emit_cnt;
    if (held >= row_shift) begin
      emit_blended(px.green, px.blue, 1'b0);
    end
    if (last) begin
      // row end: flush everything still held, white neighbours
      held = col_cnt + 1 - emit_cnt;
      while (held > 0 && blended_q.size() - first < WIN_DEPTH) begin
        emit_blended(CH_WHITE, CH_WHITE, held == 1);
        held--;
      end
      col_cnt  = 0;
      emit_cnt = 0;
      row_open = 1'b0;
    end else begin
      col_cnt++;
    end
    if (blended_q.size() > first) blended_q[$].run_last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] expv,
                             input logic [CH_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      mismatch_count++;
    end
  endtask

  // monitor: sample handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      // output first, so a word cannot match a prediction made at this edge
      if (pix_out.valid && pix_out.ready) begin
        got.red      = pix_out.out_red;
        got.green    = pix_out.out_green;
        got.blue     = pix_out.out_blue;
        got.alpha    = pix_out.out_alpha;
        got.row_end  = pix_out.row_end_out;
        got.run_last = pix_out.run_last;
        out_taken    = 1'b1;
        if (blended_q.size() == 0) begin
          $error("unexpected output word: red %0d green %0d blue %0d alpha %0d",
                 got.red, got.green, got.blue, got.alpha);
          mismatch_count++;
        end else begin
          want = blended_q.pop_front();
          check_field("out_red", want.red, got.red);
          check_field("out_green", want.green, got.green);
          check_field("out_blue", want.blue, got.blue);
          check_field("out_alpha", want.alpha, got.alpha);
          check_field("row_end_out", CH_W'(want.row_end), CH_W'(got.row_end));
          check_field("run_last", CH_W'(want.run_last), CH_W'(got.run_last));
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        seen_px.red   = pix_in.in_red;
        seen_px.green = pix_in.in_green;
        seen_px.blue  = pix_in.in_blue;
        seen_px.alpha = pix_in.in_alpha;
        blend_pixel(seen_px, pix_in.row_end_in);
        in_taken    = 1'b1;
        idle_cycles = 0;
      end else if (blended_q.size() == 0) begin
        idle_cycles++;
      end else begin
        idle_cycles = 0;
      end
      if (cfg.valid && cfg.ready) begin
        shift_reg   = cfg.shift;
        cfg_taken   = 1'b1;
        idle_cycles = 0;
      end
    end
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_busy  = 1'b0;
      cfg_busy = 1'b0;
      in_gap   = 0;
      out_stall = 0;
      pix_in.valid  <= 1'b0;
      cfg.valid     <= 1'b0;
      pix_out.ready <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
        if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
        in_gap = draw_wait(in_burst);
      end
      if (cfg_taken) begin
        cfg_taken = 1'b0;
        cfg_busy  = 1'b0;
      end
      // next word from the pending queue; shift writes only when drained
      if (!in_busy && !cfg_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_q.size() > 0) begin
          if (stim_q[0].is_cfg) begin
            if (blended_q.size() == 0 && idle_cycles >= DRAIN_CYCLES) begin
              pend     = stim_q.pop_front();
              cfg_busy = 1'b1;
            end
          end else begin
            pend    = stim_q.pop_front();
            in_busy = 1'b1;
          end
        end
      end
      pix_in.valid      <= in_busy;
      pix_in.in_red     <= pend.px.red;
      pix_in.in_green   <= pend.px.green;
      pix_in.in_blue    <= pend.px.blue;
      pix_in.in_alpha   <= pend.px.alpha;
      pix_in.row_end_in <= pend.row_end;
      cfg.valid         <= cfg_busy;
      cfg.shift         <= pend.shift;

      // receiver stalls
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
        out_stall = draw_wait(out_burst);
      end
      if (out_stall > 0) begin
        out_stall--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int len;
    int cut;
    int total;
    rst               = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.in_red     = '0;
    pix_in.in_green   = '0;
    pix_in.in_blue    = '0;
    pix_in.in_alpha   = '0;
    pix_in.row_end_in = 1'b0;
    pix_out.ready     = 1'b0;
    cfg.valid         = 1'b0;
    cfg.shift         = '0;
    pend              = '{default: '0};

    // reset shift, channel extremes
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pixel(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
    add_pixel(8'hff, 8'h00, 8'hff, 8'h00, 1'b0);
    add_pixel(8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0);
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // zero shift behaves as one
    add_shift('0);
    repeat (3) add_rand_pixel(1'b0);
    add_rand_pixel(1'b1);
    // widest shift: short row, then a single pixel row
    add_shift('1);
    repeat (2) add_rand_pixel(1'b0);
    add_rand_pixel(1'b1);
    add_rand_pixel(1'b1);
    // write in the middle of a row only applies from the next row
    repeat (2) add_rand_pixel(1'b0);
    add_shift(SHIFT_W'(2));
    repeat (2) add_rand_pixel(1'b0);
    add_rand_pixel(1'b1);
    repeat (3) add_rand_pixel(1'b0);
    add_rand_pixel(1'b1);

    // random rows, shift changed now and then
    total = 0;
    while (total < RAND_PIXELS) begin
      if ($urandom_range(0, 3) == 0) add_shift(pick_shift());
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
      cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (cut != 0 && i == cut) add_shift(pick_shift());
        add_rand_pixel(i == len - 1);
      end
      total += len;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_busy || cfg_busy) @(posedge clk);
    while (blended_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_rgb_split_screen_blend_top: done, clean");
    end else begin
      $display("tb_rgb_split_screen_blend_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_rgb_split_screen_blend_top: done, errors");
    $finish;
  end

endmodule
